>>> rtl/core/msrt_pkg.sv
`default_nettype none

package msrt_pkg;

    // bank geometry
    localparam int NUM_SLOTS   = 8;
    localparam int COUNT_WIDTH = 16;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int REPEAT_W = 16;
    localparam int MASK_W   = 8;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_CANCEL = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_RESUME = 3'd4
    } op_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                   valid;
        op_t                    op;
        logic [COUNT_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0] repeat_count;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/msrt_cell.sv
`default_nettype none

// One timer slot. Takes the broadcast command, keeps its own counters and
// extends the live chain toward the next cell.
module msrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire msrt_pkg::cmd_t cmd,
    input  wire logic          sel,
    input  wire logic          live_in,
    output logic               live_out,
    output logic               fired
);
    import msrt_pkg::*;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] ticks_reg, ticks_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] firings_reg, firings_next;

    logic                   live;
    logic [COUNT_WIDTH-1:0] ticks_dec;

    assign live = (mode_reg == MODE_RUN) || (mode_reg == MODE_PAUSE);

    // saturating countdown
    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - 1'b1 : '0;

    // next-state logic
    always_comb
    begin
        mode_next    = mode_reg;
        ticks_next   = ticks_reg;
        reload_next  = reload_reg;
        firings_next = firings_reg;
        fired        = 1'b0;
        if (cmd.valid)
        begin
            case (cmd.op)
                OP_TICK:
                begin
                    if (live)
                    begin
                        ticks_next = ticks_dec;
                        if (mode_reg == MODE_RUN && ticks_dec == '0)
                        begin
                            fired      = 1'b1;
                            ticks_next = reload_reg;
                            if (firings_reg == COUNT_WIDTH'(1))
                                mode_next = MODE_FREE;
                            else if (firings_reg != '0)
                                firings_next = firings_reg - 1'b1;
                        end
                    end
                end
                OP_ADD:
                begin
                    if (sel)
                    begin
                        ticks_next   = cmd.period;
                        reload_next  = cmd.period;
                        firings_next = cmd.repeat_count;
                        mode_next    = MODE_RUN;
                    end
                end
                OP_CANCEL:
                begin
                    if (sel)
                        mode_next = MODE_FREE;
                end
                OP_PAUSE:
                begin
                    if (sel && live)
                        mode_next = MODE_PAUSE;
                end
                OP_RESUME:
                begin
                    if (sel && live)
                        mode_next = MODE_RUN;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // live chain uses the state after this item
    assign live_out = live_in || (mode_next == MODE_RUN) || (mode_next == MODE_PAUSE);

    // mode is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_FREE;
        else
            mode_reg <= mode_next;
    end

    // counters, read only while the slot is live
    always_ff @(posedge clk)
    begin
        ticks_reg   <= ticks_next;
        reload_reg  <= reload_next;
        firings_reg <= firings_next;
    end

    // a firing comes only from a running slot on a tick
    a_fire_run: assert property (@(posedge clk) disable iff (!rst_n)
        fired |-> (mode_reg == MODE_RUN && cmd.op == OP_TICK))
        else $error("slot fired while not running on a tick");

    // a one-shot slot frees itself on its firing
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (fired && firings_reg == COUNT_WIDTH'(1)) |=> (mode_reg == MODE_FREE))
        else $error("slot still live after its last firing");

endmodule

`default_nettype wire

>>> rtl/core/multi_slot_repeat_timer.sv
//  channel   | signals                              | transfer
//  ----------+--------------------------------------+---------------------------
//  command   | start, busy, op, slot, period,       | start && !busy at clk edge
//            | repeat_count                         |
//  result    | done, fired_mask, any_active         | done high for one cycle
//
//  A command is taken every cycle (busy stays low); its result appears
//  with done in the following cycle, set by the single register stage behind the
//  slot cells. Throughput is one item per clock.
//  Reset clears every slot to free; counters are loaded by add before use.
//  The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module multi_slot_repeat_timer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [msrt_pkg::OP_W-1:0]     op,
    input  wire logic [msrt_pkg::SLOT_W-1:0]   slot,
    input  wire logic [msrt_pkg::PERIOD_W-1:0] period,
    input  wire logic [msrt_pkg::REPEAT_W-1:0] repeat_count,
    output logic                               done,
    output logic [msrt_pkg::MASK_W-1:0]        fired_mask,
    output logic                               any_active
);
    import msrt_pkg::*;

    cmd_t                 cmd;
    logic                 accept;
    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] fired;
    logic [NUM_SLOTS:0]   live_chain;
    logic [MASK_W-1:0]    mask_next;

    logic                 done_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic                 active_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // broadcast command, fields sized to the counter width
    assign cmd.valid        = accept;
    assign cmd.op           = op_t'(op);
    assign cmd.period       = COUNT_WIDTH'(period);
    assign cmd.repeat_count = COUNT_WIDTH'(repeat_count);

    // slot decode; an index beyond the bank selects nothing
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            sel[i] = (32'(slot) == i);
    end

    assign live_chain[0] = 1'b0;

    // row of slot cells
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        msrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .sel      (sel[g]),
            .live_in  (live_chain[g]),
            .live_out (live_chain[g+1]),
            .fired    (fired[g])
        );
    end

    // slots below MASK_W are reported in the mask; with MASK_W equal to NUM_SLOTS that is every slot
    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (i < MASK_W)
                mask_next[i] = fired[i];
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg   <= mask_next;
            active_reg <= live_chain[NUM_SLOTS];
        end
    end

    assign done       = done_reg;
    assign fired_mask = mask_reg;
    assign any_active = active_reg;

    // every result follows a transfer in the previous cycle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result without a command");

    // only a tick reports firings
    a_mask_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fired_mask != '0) |-> ($past(op) == OP_TICK))
        else $error("firing reported for a non-tick command");

    // an empty bank cannot fire on the next tick
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !any_active && accept && op == OP_TICK) |=> (fired_mask == '0))
        else $error("firing from an empty bank");

endmodule

`default_nettype wire
